/* hw/rtl/fuzzy_rule_inference_two_axis_core_defines.svh */
// Assertion macros for the fuzzy inference core checker
`ifndef FUZZY_RULE_INFERENCE_TWO_AXIS_CORE_DEFINES_SVH
`define FUZZY_RULE_INFERENCE_TWO_AXIS_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FRI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fri check failed");
// next-cycle implication outside reset
`define FRI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fri check failed");
`endif

/* hw/rtl/fria_pkg.sv */
package fria_pkg;

	localparam int unsigned SampleCount = 801;
	localparam int unsigned NAngle = 13;
	localparam int unsigned NDist = 7;

	typedef enum logic [1:0] {
		OP_LOAD_ANGLE = 2'd0,
		OP_LOAD_DIST  = 2'd1,
		OP_QUERY      = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef logic [3:0] set_t;

	localparam set_t S_TB = 4'd0, S_VFB = 4'd1, S_FB = 4'd2, S_B = 4'd3, S_SB = 4'd4,
		S_VSB = 4'd5, S_ST = 4'd6, S_VSF = 4'd7, S_SF = 4'd8, S_F = 4'd9,
		S_FF = 4'd10, S_VFF = 4'd11, S_TF = 4'd12;

	// set shape: peak and side lengths (short side 50, long side 100)
	function automatic logic [9:0] set_peak(input set_t s);
		case (s)
			S_TB: return 10'd50;
			S_VFB: return 10'd100;
			S_FB: return 10'd150;
			S_B: return 10'd200;
			S_SB: return 10'd250;
			S_VSB: return 10'd300;
			S_ST: return 10'd400;
			S_VSF: return 10'd500;
			S_SF: return 10'd550;
			S_F: return 10'd600;
			S_FF: return 10'd650;
			S_VFF: return 10'd700;
			default: return 10'd750;
		endcase
	endfunction

	function automatic logic left_long(input set_t s);
		return (s == S_ST) || (s == S_VSF);
	endfunction

	function automatic logic right_long(input set_t s);
		return (s == S_ST) || (s == S_VSB);
	endfunction

	// rule tables by angle row and distance column
	function automatic set_t rule_vx(input logic [3:0] a, input logic [2:0] d);
		set_t r [0:6];
		case (a)
			4'd0, 4'd12: r = '{S_ST, S_VSB, S_SB, S_B, S_FB, S_VFB, S_TB};
			4'd1, 4'd11: r = '{S_ST, S_B, S_B, S_FB, S_FB, S_VFB, S_TB};
			4'd2, 4'd10: r = '{S_ST, S_VSB, S_SB, S_B, S_B, S_FB, S_VFB};
			4'd4, 4'd8: r = '{S_ST, S_VSF, S_SF, S_F, S_F, S_FF, S_VFF};
			4'd5, 4'd7: r = '{S_ST, S_F, S_F, S_FF, S_FF, S_VFF, S_TF};
			4'd6: r = '{S_ST, S_VSF, S_SF, S_F, S_FF, S_VFF, S_TF};
			default: r = '{S_ST, S_ST, S_ST, S_ST, S_ST, S_ST, S_ST};
		endcase
		return (d < 3'd7) ? r[d] : S_ST;
	endfunction

	function automatic set_t rule_vy(input logic [3:0] a, input logic [2:0] d);
		set_t r [0:6];
		case (a)
			4'd1, 4'd5: r = '{S_ST, S_VSF, S_VSF, S_SF, S_SF, S_F, S_FF};
			4'd2, 4'd4: r = '{S_ST, S_SF, S_F, S_FF, S_FF, S_VFF, S_TF};
			4'd3: r = '{S_ST, S_VSF, S_SF, S_F, S_FF, S_VFF, S_TF};
			4'd7, 4'd11: r = '{S_ST, S_VSB, S_VSB, S_SB, S_SB, S_B, S_FB};
			4'd8, 4'd10: r = '{S_ST, S_SB, S_B, S_FB, S_FB, S_VFB, S_TB};
			4'd9: r = '{S_ST, S_VSB, S_SB, S_B, S_FB, S_VFB, S_TB};
			default: r = '{S_ST, S_ST, S_ST, S_ST, S_ST, S_ST, S_ST};
		endcase
		return (d < 3'd7) ? r[d] : S_ST;
	endfunction

endpackage

/* hw/rtl/fuzzy_rule_inference_two_axis_core.sv */
// Mamdani min-max fuzzy inference core, two speed axes.
// Input channel (in_valid/in_stall) carries op, term, degree and sample_index.
// Loads (op 0 angle, op 1 distance) store a degree and give no
// result; out-of-range terms and op 3 are dropped.
// A query (op 2) walks all 91 rules of each axis through one shared
// membership/clip/max unit, one rule per cycle: Vx then Vy, then the
// result is placed in the output register. A sample beyond 800 skips
// the walk and returns zero degrees.
// One item in flight; in_stall is high while a query is worked on or a
// result waits.
// The output register holds its payload while out_stall is high.
// Reset clears all stored degrees to zero and empties the output.
module fuzzy_rule_inference_two_axis_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [3:0] term,
	input  logic [7:0] degree,
	input  logic [9:0] sample_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [9:0] echo_index,
	output logic [7:0] vx_degree,
	output logic [7:0] vy_degree
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

	state_t     state_q;
	logic [7:0] ang_q [0:12];
	logic [7:0] dst_q [0:6];
	logic [3:0] a_q;
	logic [2:0] d_q;
	logic       axis_q;
	logic [9:0] idx_q;
	logic [7:0] vx_q;
	logic [7:0] vy_q;
	logic       in_xfer;
	logic       clear;
	logic       en;
	fria_pkg::set_t set_sel;
	logic [7:0] av, dv, strength, acc;
	logic       last;

	assign in_xfer = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign echo_index = idx_q;
	assign vx_degree = vx_q;
	assign vy_degree = vy_q;

	// select rule operands
	always_comb begin
		av = ang_q[a_q];
		dv = dst_q[d_q];
		strength = (av < dv) ? av : dv;
		set_sel = axis_q ? fria_pkg::rule_vy(a_q, d_q) : fria_pkg::rule_vx(a_q, d_q);
		last = (a_q == 4'(fria_pkg::NAngle - 1)) && (d_q == 3'(fria_pkg::NDist - 1));
		en = (state_q == ST_RUN);
		clear = in_xfer || (en && last && !axis_q);
	end

	fria_rule_unit u_unit (
		.clk(clk), .clear(clear), .en(en), .set_sel(set_sel),
		.x(idx_q), .strength(strength), .acc(acc)
	);

	// store loaded degrees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 13; i++) ang_q[i] <= '0;
			for (int i = 0; i < 7; i++) dst_q[i] <= '0;
		end else if (in_xfer) begin
			if (op == fria_pkg::OP_LOAD_ANGLE && term < 4'(fria_pkg::NAngle))
				ang_q[term] <= degree;
			if (op == fria_pkg::OP_LOAD_DIST && term < 4'(fria_pkg::NDist))
				dst_q[term[2:0]] <= degree;
		end
	end

	// sequence the rule walk and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q <= '0;
			d_q <= '0;
			axis_q <= 1'b0;
			idx_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && op == fria_pkg::OP_QUERY) begin
						idx_q <= sample_index;
						a_q <= '0;
						d_q <= '0;
						axis_q <= 1'b0;
						if (sample_index >= 10'(fria_pkg::SampleCount)) begin
							vx_q <= '0;
							vy_q <= '0;
							state_q <= ST_OUT;
						end else
							state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last) begin
						a_q <= '0;
						d_q <= '0;
						if (!axis_q) begin
							vx_q <= acc;
							axis_q <= 1'b1;
						end else begin
							vy_q <= acc;
							state_q <= ST_OUT;
						end
					end else if (d_q == 3'(fria_pkg::NDist - 1)) begin
						d_q <= '0;
						a_q <= a_q + 4'd1;
					end else
						d_q <= d_q + 3'd1;
				end
				ST_OUT: begin
					if (!out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/fria_rule_unit.sv */
// Shared evaluation unit: membership of one set at one sample, clipped by strength,
// folded into a running maximum.
module fria_rule_unit (
	input  logic                clk,
	input  logic                clear,
	input  logic                en,
	input  fria_pkg::set_t      set_sel,
	input  logic [9:0]          x,
	input  logic [7:0]          strength,
	output logic [7:0]          acc
);

	logic [9:0] peak;
	logic [10:0] span;
	logic        is_long;
	logic [9:0] mu_w;
	logic [7:0] mu;
	logic [7:0] clip;
	logic [7:0] acc_q;

	// distance from peak and ramp height
	always_comb begin
		peak = fria_pkg::set_peak(set_sel);
		if (x <= peak) begin
			span = {1'b0, peak - x};
			is_long = fria_pkg::left_long(set_sel);
		end else begin
			span = {1'b0, x - peak};
			is_long = fria_pkg::right_long(set_sel);
		end
		if (is_long)
			mu_w = (span >= 11'd100) ? 10'd0 : 10'(11'd200 - {span[9:0], 1'b0});
		else
			mu_w = (span >= 11'd50) ? 10'd0 : 10'(11'd200 - {span[8:0], 2'b00});
		mu = mu_w[7:0];
		clip = (mu < strength) ? mu : strength;
	end

	// running maximum including the rule evaluated this cycle
	assign acc = (en && clip > acc_q) ? clip : acc_q;

	// hold running maximum
	always_ff @(posedge clk) begin
		if (clear)
			acc_q <= '0;
		else
			acc_q <= acc;
	end

endmodule

/* hw/rtl/fria_checker.sv */
`include "fuzzy_rule_inference_two_axis_core_defines.svh"
// Port-level checks on the fuzzy inference core
module fria_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [9:0] echo_index,
	input logic [7:0] vx_degree,
	input logic [7:0] vy_degree
);

	`FRI_ASSERT_IMP(a_vx_range, out_valid, vx_degree <= 8'd200)
	`FRI_ASSERT_IMP(a_vy_range, out_valid, vy_degree <= 8'd200)
	`FRI_ASSERT_IMP(a_busy_out, out_valid, in_stall)
	`FRI_ASSERT_IMP(a_no_in_with_out, in_valid && !in_stall, !out_valid)
	`FRI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(echo_index))

endmodule

bind fuzzy_rule_inference_two_axis_core fria_checker u_fria_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .echo_index(echo_index),
	.vx_degree(vx_degree), .vy_degree(vy_degree)
);
